>>> sv/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types for the lru key/value cache: update commands and scan flags
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // update broadcast to every cell at the end of a scan
  typedef enum logic [2:0] {
    UPD_NONE          = 3'd0,
    UPD_PROMOTE       = 3'd1,  // access hit: make target most recent
    UPD_WRITE_PROMOTE = 3'd2,  // add hit: new value, most recent
    UPD_FILL          = 3'd3,  // add miss into an empty slot
    UPD_REPLACE       = 3'd4   // add miss over the lru victim
  } upd_e;

  // flags carried along the cell chain with the scan token
  typedef struct packed {
    logic found;    // a slot in use holds the key
    logic empty;    // an empty slot in use was seen
    logic vic_set;  // a victim candidate was taken
  } scan_flags_t;

endpackage

>>> sv/lkvc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cell
// one cache slot: holds key, value, valid and recency rank, adds its view to
// the scan record passing by and applies the broadcast update
// ----------------------------------------------------------------------------
module lkvc_cell import lkvc_pkg::*; #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned MAX_SLOTS  = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 16,
  localparam int unsigned AW = $clog2(MAX_SLOTS),
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CW-1:0]         cap_i,
  input  logic [KEY_BITS-1:0]   key_i,
  // update broadcast
  input  upd_e                  cmd_kind_i,
  input  logic [AW-1:0]         cmd_tgt_i,
  input  logic [AW-1:0]         cmd_age_i,
  input  logic [VALUE_BITS-1:0] cmd_value_i,
  // scan record from the previous cell
  input  logic                  tok_i,
  input  scan_flags_t           flags_i,
  input  logic [AW-1:0]         fidx_i,
  input  logic [AW-1:0]         fage_i,
  input  logic [VALUE_BITS-1:0] fval_i,
  input  logic [AW-1:0]         eidx_i,
  input  logic [AW-1:0]         vidx_i,
  input  logic [AW-1:0]         vage_i,
  // scan record to the next cell
  output logic                  tok_o,
  output scan_flags_t           flags_o,
  output logic [AW-1:0]         fidx_o,
  output logic [AW-1:0]         fage_o,
  output logic [VALUE_BITS-1:0] fval_o,
  output logic [AW-1:0]         eidx_o,
  output logic [AW-1:0]         vidx_o,
  output logic [AW-1:0]         vage_o
);

  localparam logic [AW-1:0] MY_IDX  = AW'(IDX);
  localparam logic [CW-1:0] MY_POS  = CW'(IDX);
  localparam logic [AW-1:0] AGE_MAX = AW'(MAX_SLOTS - 1);

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [AW-1:0]         age_q, age_d;

  logic                  tok_q;
  scan_flags_t           flags_q, flags_d;
  logic [AW-1:0]         fidx_q, fidx_d, fage_q, fage_d;
  logic [VALUE_BITS-1:0] fval_q, fval_d;
  logic [AW-1:0]         eidx_q, eidx_d, vidx_q, vidx_d, vage_q, vage_d;

  logic in_use;
  logic is_tgt;

  assign in_use = MY_POS < cap_i;
  assign is_tgt = cmd_tgt_i == MY_IDX;

  // scan: later cells override, so the highest match / empty slot wins;
  // victim moves only on a strictly larger rank
  always_comb begin
    flags_d = flags_i;
    fidx_d  = fidx_i;
    fage_d  = fage_i;
    fval_d  = fval_i;
    eidx_d  = eidx_i;
    vidx_d  = vidx_i;
    vage_d  = vage_i;
    if (in_use) begin
      if (valid_q && key_q == key_i) begin
        flags_d.found = 1'b1;
        fidx_d        = MY_IDX;
        fage_d        = age_q;
        fval_d        = val_q;
      end
      if (!valid_q) begin
        flags_d.empty = 1'b1;
        eidx_d        = MY_IDX;
      end
      if (!flags_i.vic_set || age_q > vage_i) begin
        flags_d.vic_set = 1'b1;
        vidx_d          = MY_IDX;
        vage_d          = age_q;
      end
    end
  end

  // update
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    val_d   = val_q;
    age_d   = age_q;
    case (cmd_kind_i) inside
      UPD_PROMOTE, UPD_WRITE_PROMOTE, UPD_REPLACE: begin
        if (is_tgt) begin
          age_d = '0;
          if (cmd_kind_i != UPD_PROMOTE) val_d = cmd_value_i;
          if (cmd_kind_i == UPD_REPLACE) key_d = key_i;
        end else if (valid_q && age_q < cmd_age_i) begin
          age_d = age_q + 1'b1;
        end
      end
      UPD_FILL: begin
        if (is_tgt) begin
          valid_d = 1'b1;
          key_d   = key_i;
          val_d   = cmd_value_i;
          age_d   = '0;
        end else if (valid_q && age_q != AGE_MAX) begin
          age_d = age_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    val_q   <= val_d;
    age_q   <= age_d;
    flags_q <= flags_d;
    fidx_q  <= fidx_d;
    fage_q  <= fage_d;
    fval_q  <= fval_d;
    eidx_q  <= eidx_d;
    vidx_q  <= vidx_d;
    vage_q  <= vage_d;
  end

  assign tok_o   = tok_q;
  assign flags_o = flags_q;
  assign fidx_o  = fidx_q;
  assign fage_o  = fage_q;
  assign fval_o  = fval_q;
  assign eidx_o  = eidx_q;
  assign vidx_o  = vidx_q;
  assign vage_o  = vage_q;

endmodule

>>> sv/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// fully associative key/value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// An item is either an add (operation 0: store value under key) or an access
// (operation 1: look up key, one result with hit and data). Adds give no
// result. The slots form a chain of cells; an accepted item launches a scan
// token that walks the chain one cell per cycle, collecting the matching
// slot, the highest empty slot and the lru victim. When the token leaves the
// last cell the update is broadcast to all cells in that same cycle. An item
// is therefore not taken until the token of the previous one has left the
// chain and, for an access, its result has found room in the output register;
// that result then waits there while the next item is taken.
// slots_in_use (address 0) limits the slots searched and replaced; 0 acts
// as 1 and values above MAX_SLOTS as MAX_SLOTS. No clearing pass: valid bits
// reset with the block.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top import lkvc_pkg::*; #(
  parameter int unsigned MAX_SLOTS  = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] data_o
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  localparam logic       OP_ADD     = 1'b0;
  localparam logic       OP_ACCESS  = 1'b1;
  localparam logic [1:0] ADDR_SLOTS = 2'd0;
  localparam logic [4:0] SLOTS_RST  = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_STALL = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [4:0]            slots_q;
  logic [CW-1:0]         cap;
  logic                  cfg_wr;

  logic                  req_op_q;
  logic [KEY_BITS-1:0]   req_key_q;
  logic [VALUE_BITS-1:0] req_val_q;
  logic                  start_q;

  logic                  out_valid_q;
  logic                  hit_q;
  logic [VALUE_BITS-1:0] data_q;
  logic                  pend_hit_q;
  logic [VALUE_BITS-1:0] pend_data_q;

  logic                  in_xfer;
  logic                  out_free;
  logic                  done;
  logic                  res_hit;
  logic [VALUE_BITS-1:0] res_data;

  upd_e                  cmd_kind;
  logic [AW-1:0]         cmd_tgt;
  logic [AW-1:0]         cmd_age;

  // scan record between cells; index 0 is the seed
  logic                  tok   [MAX_SLOTS+1];
  scan_flags_t           flags [MAX_SLOTS+1];
  logic [AW-1:0]         fidx  [MAX_SLOTS+1];
  logic [AW-1:0]         fage  [MAX_SLOTS+1];
  logic [VALUE_BITS-1:0] fval  [MAX_SLOTS+1];
  logic [AW-1:0]         eidx  [MAX_SLOTS+1];
  logic [AW-1:0]         vidx  [MAX_SLOTS+1];
  logic [AW-1:0]         vage  [MAX_SLOTS+1];
  logic [MAX_SLOTS:0]    tok_vec;

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(slots_q);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= SLOTS_RST;
    end else if (cfg_wr && paddr == ADDR_SLOTS) begin
      slots_q <= pwdata[4:0];
    end
  end

  // effective capacity
  always_comb begin
    if (slots_q == 5'd0) begin
      cap = CW'(1);
    end else if (32'(slots_q) > MAX_SLOTS) begin
      cap = CW'(MAX_SLOTS);
    end else begin
      cap = CW'(slots_q);
    end
  end

  // chain seed
  assign tok[0]   = start_q;
  assign flags[0] = '0;
  assign fidx[0]  = '0;
  assign fage[0]  = '0;
  assign fval[0]  = '0;
  assign eidx[0]  = '0;
  assign vidx[0]  = '0;
  assign vage[0]  = '0;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    lkvc_cell #(
      .IDX        (g),
      .MAX_SLOTS  (MAX_SLOTS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cap_i       (cap),
      .key_i       (req_key_q),
      .cmd_kind_i  (cmd_kind),
      .cmd_tgt_i   (cmd_tgt),
      .cmd_age_i   (cmd_age),
      .cmd_value_i (req_val_q),
      .tok_i       (tok[g]),
      .flags_i     (flags[g]),
      .fidx_i      (fidx[g]),
      .fage_i      (fage[g]),
      .fval_i      (fval[g]),
      .eidx_i      (eidx[g]),
      .vidx_i      (vidx[g]),
      .vage_i      (vage[g]),
      .tok_o       (tok[g+1]),
      .flags_o     (flags[g+1]),
      .fidx_o      (fidx[g+1]),
      .fage_o      (fage[g+1]),
      .fval_o      (fval[g+1]),
      .eidx_o      (eidx[g+1]),
      .vidx_o      (vidx[g+1]),
      .vage_o      (vage[g+1])
    );
  end

  for (genvar g = 0; g <= MAX_SLOTS; g++) begin : g_tok
    assign tok_vec[g] = tok[g];
  end

  // token has left the last cell: scan record complete
  assign done = tok[MAX_SLOTS];

  // choose the update from the finished scan record
  always_comb begin
    cmd_kind = UPD_NONE;
    cmd_tgt  = '0;
    cmd_age  = '0;
    if (done) begin
      if (flags[MAX_SLOTS].found) begin
        cmd_kind = (req_op_q == OP_ACCESS) ? UPD_PROMOTE : UPD_WRITE_PROMOTE;
        cmd_tgt  = fidx[MAX_SLOTS];
        cmd_age  = fage[MAX_SLOTS];
      end else if (req_op_q == OP_ADD) begin
        if (flags[MAX_SLOTS].empty) begin
          cmd_kind = UPD_FILL;
          cmd_tgt  = eidx[MAX_SLOTS];
        end else begin
          // all slots in use are valid here, so the victim rank is real
          cmd_kind = UPD_REPLACE;
          cmd_tgt  = vidx[MAX_SLOTS];
          cmd_age  = vage[MAX_SLOTS];
        end
      end
    end
  end

  // miss returns zero data
  assign res_hit  = flags[MAX_SLOTS].found;
  assign res_data = res_hit ? fval[MAX_SLOTS] : '0;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (done) begin
          if (req_op_q == OP_ACCESS && !out_free) begin
            state_d = ST_STALL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STALL: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_xfer;
      if (state_q == ST_SCAN && done && req_op_q == OP_ACCESS && out_free) begin
        out_valid_q <= 1'b1;
      end else if (state_q == ST_STALL && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_op_q  <= operation_i;
      req_key_q <= key_i;
      req_val_q <= value_i;
    end
    if (state_q == ST_SCAN && done) begin
      pend_hit_q  <= res_hit;
      pend_data_q <= res_data;
      if (out_free) begin
        hit_q  <= res_hit;
        data_q <= res_data;
      end
    end else if (state_q == ST_STALL && out_free) begin
      hit_q  <= pend_hit_q;
      data_q <= pend_data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign data_o      = data_q;

  // at most one scan token in flight along the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_vec))
    else $error("more than one scan token in the cell chain");

  // no token left in the chain once the block is ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tok_vec == '0))
    else $error("scan token alive while idle");

  // a pending result only waits behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STALL) |-> out_valid_q)
    else $error("stall with empty output register");

  // an accepted item launches exactly one scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (start_q && state_q == ST_SCAN))
    else $error("accepted item did not start a scan");

endmodule

>>> tb/lru_key_value_cache_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_test
// self-checking bench for the lru key/value cache
// ----------------------------------------------------------------------------
// Drives add and access requests through the valid/ready request channel.
// A cycle-free model of the cache computes the result of every access at the
// transfer, and each result transfer is compared against the oldest queued
// prediction. Directed tests cover hidden slots, duplicate keys, capacity
// clamping, field extremes and lru eviction. The random part runs through
// several capacities. Both sides idle at random, and the result side holds
// off for a long stretch once so that the cache stalls its input.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_test;

  localparam int unsigned MAX_SLOTS  = 16;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned VALUE_BITS = 16;

  // request codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_ACCESS = 1'b1;

  // register map
  localparam logic [1:0] ADDR_SLOTS_IN_USE = 2'd0;

  // one scan walks the cell chain; drain waits allow for a few of them
  localparam int unsigned SCAN_CYCLES    = MAX_SLOTS + 2;
  localparam int unsigned DRAIN_CYCLES   = 3 * SCAN_CYCLES;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS    = 95;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] data;
  } lookup_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [1:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  operation_i;
  logic [KEY_BITS-1:0]   key_i;
  logic [VALUE_BITS-1:0] value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  hit_o;
  logic [VALUE_BITS-1:0] data_o;

  // cache model state, mirrors the slot cells
  logic [4:0]            cfg_slots;
  logic                  slot_full  [MAX_SLOTS];
  logic [KEY_BITS-1:0]   slot_key   [MAX_SLOTS];
  logic [VALUE_BITS-1:0] slot_value [MAX_SLOTS];
  logic [3:0]            slot_rank  [MAX_SLOTS];

  lookup_result_t        pending_lookups [$];
  logic [KEY_BITS-1:0]   key_pool [32];

  int unsigned error_count  = 0;
  int unsigned stuck_cycles = 0;
  int unsigned gap_pct      = 0;  // chance of a gap before a request
  int unsigned stall_pct    = 0;  // chance of a result-side stall
  bit          hold_request = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lru_key_value_cache_top #(
    .MAX_SLOTS  (MAX_SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .data_o      (data_o)
  );

  // --------------------------------------------------------------------------
  // cache model
  // --------------------------------------------------------------------------

  // 0 acts as one slot, anything above the cell count as all cells
  function automatic int unsigned effective_capacity();
    if (cfg_slots == 5'd0) return 1;
    if (cfg_slots > MAX_SLOTS) return MAX_SLOTS;
    return cfg_slots;
  endfunction

  // slots more recent than s age by one, s becomes rank 0
  function automatic void make_most_recent(int unsigned s);
    logic [3:0] old_rank;
    old_rank = slot_rank[s];
    for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
      if (slot_full[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
    end
    slot_rank[s] = 4'd0;
  endfunction

  // highest slot in use holding the key, -1 if none
  function automatic int find_slot(logic [KEY_BITS-1:0] key, int unsigned cap);
    int found;
    found = -1;
    for (int unsigned i = 0; i < cap; i++) begin
      if (slot_full[i] && slot_key[i] == key) found = int'(i);
    end
    return found;
  endfunction

  function automatic void apply_request(logic op, logic [KEY_BITS-1:0] key,
                                        logic [VALUE_BITS-1:0] value);
    int unsigned    cap;
    int             hit_slot;
    int             empty_slot;
    int unsigned    victim;
    lookup_result_t res;
    cap      = effective_capacity();
    hit_slot = find_slot(key, cap);
    if (op == OP_ACCESS) begin
      if (hit_slot < 0) begin
        res.hit  = 1'b0;
        res.data = '0;
      end else begin
        res.hit  = 1'b1;
        res.data = slot_value[hit_slot];
        make_most_recent(hit_slot);
      end
      pending_lookups.push_back(res);
      return;
    end
    // add hit: overwrite in place
    if (hit_slot >= 0) begin
      slot_value[hit_slot] = value;
      make_most_recent(hit_slot);
      return;
    end
    empty_slot = -1;
    for (int unsigned i = 0; i < cap; i++) begin
      if (!slot_full[i]) empty_slot = int'(i);
    end
    if (empty_slot >= 0) begin
      // fill: every valid slot ages, saturating at the oldest rank
      for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
        if (slot_full[i] && slot_rank[i] < 4'(MAX_SLOTS - 1)) slot_rank[i]++;
      end
      slot_full[empty_slot]  = 1'b1;
      slot_key[empty_slot]   = key;
      slot_value[empty_slot] = value;
      slot_rank[empty_slot]  = 4'd0;
    end else begin
      // replace: oldest slot in use, lowest index on a tie
      victim = 0;
      for (int unsigned i = 1; i < cap; i++) begin
        if (slot_rank[i] > slot_rank[victim]) victim = i;
      end
      slot_key[victim]   = key;
      slot_value[victim] = value;
      make_most_recent(victim);
    end
  endfunction

  // --------------------------------------------------------------------------
  // monitor: check result transfers, then predict request transfers
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni === 1'b1) begin
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (pending_lookups.size() == 0) begin
          $error("result transfer with no access outstanding: hit %0d data %0h",
                 hit_o, data_o);
          error_count++;
        end else begin
          want = pending_lookups.pop_front();
          if (hit_o !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, hit_o);
            error_count++;
          end
          if (data_o !== want.data) begin
            $error("data mismatch: expected %0h, actual %0h", want.data, data_o);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o === 1'b1) apply_request(operation_i, key_i, value_i);
    end
  end

  // watchdog: a run with no transfer for too long is hung
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // result side: random stalls, plus one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = idle_length();
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // shared tasks, all entered and left at a rising edge
  // --------------------------------------------------------------------------

  // one request transfer; valid stays high into the next call when no gap
  task automatic send_request(input logic op, input logic [KEY_BITS-1:0] key,
                              input logic [VALUE_BITS-1:0] value);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? idle_length() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    value_i     <= value;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // all results in, then room for a trailing add still in the chain
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_slots_in_use(input logic [4:0] slots);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SLOTS_IN_USE;
    pwdata  <= {27'd0, slots};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_slots = slots;
  endtask

  task automatic reconfigure(input logic [4:0] slots);
    wait_for_drain();
    write_slots_in_use(slots);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // a slot above the capacity is not searched but comes back later, and
  // then the higher of two slots with the same key wins
  task automatic test_hidden_slots();
    send_request(OP_ADD, 16'hA000, 16'h1111);      // lands in the top slot
    reconfigure(5'd2);
    send_request(OP_ACCESS, 16'hA000, 16'h0000);   // hidden: miss
    send_request(OP_ADD, 16'hA000, 16'h2222);      // second copy in slot 1
    reconfigure(5'd16);
    send_request(OP_ACCESS, 16'hA000, 16'hFFFF);   // top slot copy wins
    send_request(OP_ADD, 16'hB000, 16'h3333);
  endtask

  // zero capacity behaves as a single slot
  task automatic test_capacity_zero();
    reconfigure(5'd0);
    send_request(OP_ADD, 16'hC000, 16'h4444);
    send_request(OP_ADD, 16'hD000, 16'h5555);      // evicts the previous key
    send_request(OP_ACCESS, 16'hC000, 16'h0000);
    send_request(OP_ACCESS, 16'hD000, 16'h0000);
  endtask

  // largest register value clamps to all cells; keys and values at extremes
  task automatic test_field_extremes();
    reconfigure(5'd31);
    send_request(OP_ADD, 16'h0000, 16'hFFFF);
    send_request(OP_ADD, 16'hFFFF, 16'h0000);
    send_request(OP_ACCESS, 16'h0000, 16'h0000);
    send_request(OP_ACCESS, 16'hFFFF, 16'hFFFF);
    send_request(OP_ADD, 16'h0000, 16'h5A5A);      // update in place
    send_request(OP_ACCESS, 16'h0000, 16'hA5A5);
    send_request(OP_ACCESS, 16'h1234, 16'h0000);   // never added
  endtask

  // small capacity: a hit protects a key, the oldest one goes
  task automatic test_lru_eviction();
    reconfigure(5'd3);
    send_request(OP_ADD, 16'hE000, 16'h6666);
    send_request(OP_ACCESS, 16'hD000, 16'h0000);
    send_request(OP_ADD, 16'hF000, 16'h7777);
    send_request(OP_ACCESS, 16'hA000, 16'h0000);
    send_request(OP_ACCESS, 16'hD000, 16'h0000);
    send_request(OP_ACCESS, 16'hE000, 16'h0000);
    send_request(OP_ACCESS, 16'hF000, 16'h0000);
  endtask

  // result side holds off while requests keep coming back to back
  task automatic test_output_backpressure();
    reconfigure(5'd16);
    gap_pct      = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_request((i % 4 == 0) ? OP_ADD : OP_ACCESS,
                   key_pool[$urandom_range(0, 19)], 16'($urandom));
    end
  endtask

  // random traffic over a series of capacities, mostly from a small key set
  // so that hits, updates and evictions are frequent
  task automatic test_random_traffic();
    logic [4:0]          caps [9];
    int unsigned         pool_n;
    logic [KEY_BITS-1:0] key;
    caps = '{5'd16, 5'd1, 5'd31, 5'd7, 5'd0, 5'd2, 5'd12, 5'd17, 5'(0)};
    caps[8] = 5'($urandom_range(0, 31));
    for (int p = 0; p < 9; p++) begin
      reconfigure(caps[p]);
      // of every three phases, one has no request gaps and one no result stalls
      gap_pct   = (p % 3 == 0) ? 0 : 30;
      stall_pct = (p % 3 == 1) ? 0 : 25;
      pool_n    = effective_capacity() + 6;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_n - 1)];
        else key = KEY_BITS'($urandom);
        send_request(1'($urandom_range(0, 1)), key, VALUE_BITS'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = ADDR_SLOTS_IN_USE;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_ADD;
    key_i       = '0;
    value_i     = '0;
    // model after reset: all slots empty, full capacity
    cfg_slots   = 5'd16;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_full[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_rank[i]  = '0;
    end
    for (int i = 0; i < 32; i++) key_pool[i] = KEY_BITS'($urandom);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 20;
    stall_pct = 20;
    test_hidden_slots();
    test_capacity_zero();
    test_field_extremes();
    test_lru_eviction();
    test_output_backpressure();
    test_random_traffic();

    wait_for_drain();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
